[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL of the gravity accumulator (used by its top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define NGA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define NGA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hw/rtl/nga_pkg.sv]
// Shared types, widths and constants of the gravity accumulator.
package nga_pkg;

   localparam int POS_W  = 40;
   localparam int MAG_W  = 41;
   localparam int VEL_W  = 32;
   localparam int SUM_W  = 48;
   localparam int GRAV_W = 32;
   localparam int MIN_W  = 39;
   localparam int MASS_W = 40;
   localparam int WIDE_W = 128;
   localparam int R3_W   = 123;
   localparam int GM_W   = 72;
   localparam int QUO_W  = 49;
   localparam int DSH_W  = R3_W + SUM_W;
   localparam int CNT_W  = 6;

   localparam int DIV_STEPS  = 49;
   localparam int SQRT_STEPS = 41;

   localparam logic [GRAV_W-1:0] GRAV_RESET = 32'd437387264;
   localparam logic [MIN_W-1:0]  MIN_RESET  = 39'd5000000;

   // Register indexes of the CSR port
   localparam logic CSR_GRAV = 1'b0;
   localparam logic CSR_MIN  = 1'b1;

   typedef logic [1:0] eng_op_type;
   localparam eng_op_type OP_MUL  = 2'd0;
   localparam eng_op_type OP_DIV  = 2'd1;
   localparam eng_op_type OP_SQRT = 2'd2;

   typedef struct packed {
      logic       start;
      eng_op_type op;
   } eng_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } eng_sts_type;

   // Subtract or add a term magnitude and clamp to the 48-bit range.
   function automatic logic signed [SUM_W-1:0] sat_acc(
      input logic signed [SUM_W-1:0] sum,
      input logic                    add_term,
      input logic [QUO_W-1:0]        mag
   );
      logic signed [SUM_W+1:0] s_ext;
      logic signed [SUM_W+1:0] m_ext;
      logic signed [SUM_W+1:0] t;
      s_ext = {{2{sum[SUM_W-1]}}, sum};
      m_ext = {1'b0, mag};
      t = add_term ? (s_ext + m_ext) : (s_ext - m_ext);
      if (t > $signed({3'b000, {(SUM_W-1){1'b1}}})) begin
         sat_acc = {1'b0, {(SUM_W-1){1'b1}}};
      end else if (t < $signed({3'b111, {(SUM_W-1){1'b0}}})) begin
         sat_acc = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         sat_acc = t[SUM_W-1:0];
      end
   endfunction

endpackage

[hw/rtl/nga_engine.sv]
// Shared iterative engine: shift-add multiply, restoring divide, integer square root.
module nga_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  nga_pkg::eng_cmd_type              cmd,
   input  logic [nga_pkg::WIDE_W-1:0]        opnd_a,
   input  logic [nga_pkg::R3_W-1:0]          opnd_b,
   output nga_pkg::eng_sts_type              sts,
   output logic [nga_pkg::WIDE_W-1:0]        res_wide,
   output logic [nga_pkg::QUO_W-1:0]         res_narrow
);

   logic                              busy_ff;
   logic                              done_ff;
   nga_pkg::eng_op_type               op_ff;
   logic [nga_pkg::CNT_W-1:0]         cnt_ff;
   logic [nga_pkg::WIDE_W-1:0]        acc_ff;
   logic [nga_pkg::DSH_W-1:0]         opa_ff;
   logic [nga_pkg::QUO_W-1:0]         opb_ff;

   logic [nga_pkg::WIDE_W-1:0]        mul_sum;
   logic                              div_ge;
   logic [nga_pkg::WIDE_W-1:0]        div_diff;
   logic [45:0]                       sq_rem;
   logic [45:0]                       sq_trial;
   logic                              sq_ge;
   logic                              last_step;

   // Step arithmetic for each operation
   always_comb begin
      mul_sum   = acc_ff + opa_ff[nga_pkg::WIDE_W-1:0];
      div_ge    = {{(nga_pkg::DSH_W-nga_pkg::WIDE_W){1'b0}}, acc_ff} >= opa_ff;
      div_diff  = acc_ff - opa_ff[nga_pkg::WIDE_W-1:0];
      sq_rem    = {acc_ff[43:0], opa_ff[81:80]};
      sq_trial  = {1'b0, opb_ff[42:0], 2'b01};
      sq_ge     = sq_rem >= sq_trial;
      last_step = (cnt_ff == '0);
   end

   // Sequence control: busy while iterating, one-cycle done at the end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= nga_pkg::OP_MUL;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            op_ff   <= cmd.op;
         end else if (busy_ff) begin
            unique case (op_ff) inside
               nga_pkg::OP_MUL: begin
                  if (opb_ff == '0) begin
                     busy_ff <= 1'b0;
                     done_ff <= 1'b1;
                  end
               end
               nga_pkg::OP_DIV, nga_pkg::OP_SQRT: begin
                  if (last_step) begin
                     busy_ff <= 1'b0;
                     done_ff <= 1'b1;
                  end
               end
               default: begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end
            endcase
         end
      end
   end

   // Datapath: load operands, then one bit or one root digit per cycle
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         unique case (cmd.op)
            nga_pkg::OP_DIV: begin
               acc_ff <= opnd_a;
               opa_ff <= {opnd_b, {nga_pkg::SUM_W{1'b0}}};
               opb_ff <= '0;
               cnt_ff <= nga_pkg::CNT_W'(nga_pkg::DIV_STEPS - 1);
            end
            nga_pkg::OP_SQRT: begin
               acc_ff <= '0;
               opa_ff <= {{(nga_pkg::DSH_W-nga_pkg::WIDE_W){1'b0}}, opnd_a};
               opb_ff <= '0;
               cnt_ff <= nga_pkg::CNT_W'(nga_pkg::SQRT_STEPS - 1);
            end
            default: begin
               acc_ff <= '0;
               opa_ff <= {{(nga_pkg::DSH_W-nga_pkg::WIDE_W){1'b0}}, opnd_a};
               opb_ff <= {{(nga_pkg::QUO_W-nga_pkg::MAG_W){1'b0}},
                          opnd_b[nga_pkg::MAG_W-1:0]};
               cnt_ff <= '0;
            end
         endcase
      end else if (busy_ff) begin
         unique case (op_ff)
            nga_pkg::OP_MUL: begin
               if (opb_ff[0]) begin
                  acc_ff <= mul_sum;
               end
               opa_ff <= {opa_ff[nga_pkg::DSH_W-2:0], 1'b0};
               opb_ff <= {1'b0, opb_ff[nga_pkg::QUO_W-1:1]};
            end
            nga_pkg::OP_DIV: begin
               if (div_ge) begin
                  acc_ff <= div_diff;
               end
               opa_ff <= {1'b0, opa_ff[nga_pkg::DSH_W-1:1]};
               opb_ff <= {opb_ff[nga_pkg::QUO_W-2:0], div_ge};
               cnt_ff <= cnt_ff - 1'b1;
            end
            nga_pkg::OP_SQRT: begin
               acc_ff <= {82'd0, sq_ge ? (sq_rem - sq_trial) : sq_rem};
               opa_ff <= {opa_ff[nga_pkg::DSH_W-3:0], 2'b00};
               opb_ff <= {opb_ff[nga_pkg::QUO_W-2:0], sq_ge};
               cnt_ff <= cnt_ff - 1'b1;
            end
            default: begin
               cnt_ff <= '0;
            end
         endcase
      end
   end

   assign sts.busy   = busy_ff;
   assign sts.done   = done_ff;
   assign res_wide   = acc_ff;
   assign res_narrow = opb_ff;

endmodule

[hw/rtl/nbody_gravity_accumulator.sv]
// Gravity accumulator top level: sequencer, running sums, CSRs and result register.
// One beat on req_ names an attracting body; the block folds its pull on the query body into
// two 48-bit saturating sums and, on the beat flagged last, returns the query velocity and
// the sums on rsp_ and clears them. A skipped or massless body goes from accept straight to the
// finish state. A body that contributes runs one shared shift-add/subtract engine through two
// squares, a 41-step square root, r^2, r^3, G*m and per axis a multiply and a 49-step divide;
// that engine does one multiplier bit, one quotient bit or one root digit per cycle, and a
// multiply stops once its multiplier has no ones left, so short operands finish sooner. A body
// closer than min_distance stops after the root. req_ready is high only between bodies; a last
// beat waits while a previous result is still unclaimed on rsp_. CSR writes take effect at
// once and belong between bodies.
`include "assert_macros.svh"

module nbody_gravity_accumulator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [nga_pkg::POS_W-1:0]    req_query_x,
   input  logic signed [nga_pkg::POS_W-1:0]    req_query_y,
   input  logic signed [nga_pkg::VEL_W-1:0]    req_query_vx,
   input  logic signed [nga_pkg::VEL_W-1:0]    req_query_vy,
   input  logic signed [nga_pkg::POS_W-1:0]    req_other_x,
   input  logic signed [nga_pkg::POS_W-1:0]    req_other_y,
   input  logic        [nga_pkg::MASS_W-1:0]   req_other_mass,
   input  logic                                req_skip,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [nga_pkg::VEL_W-1:0]    rsp_vel_x,
   output logic signed [nga_pkg::VEL_W-1:0]    rsp_vel_y,
   output logic signed [nga_pkg::SUM_W-1:0]    rsp_acc_x,
   output logic signed [nga_pkg::SUM_W-1:0]    rsp_acc_y,
   input  logic                                csr_write_en,
   input  logic                                csr_index,
   input  logic        [nga_pkg::MIN_W-1:0]    csr_wdata
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SQX  = 4'd1;
   localparam logic [3:0] ST_SQY  = 4'd2;
   localparam logic [3:0] ST_ROOT = 4'd3;
   localparam logic [3:0] ST_R2   = 4'd4;
   localparam logic [3:0] ST_R3   = 4'd5;
   localparam logic [3:0] ST_GM   = 4'd6;
   localparam logic [3:0] ST_NX   = 4'd7;
   localparam logic [3:0] ST_DX   = 4'd8;
   localparam logic [3:0] ST_NY   = 4'd9;
   localparam logic [3:0] ST_DY   = 4'd10;
   localparam logic [3:0] ST_FIN  = 4'd11;

   logic [3:0]                         state_ff;
   logic                               issued_ff;
   logic [nga_pkg::GRAV_W-1:0]         grav_ff;
   logic [nga_pkg::MIN_W-1:0]          min_dist_ff;
   logic signed [nga_pkg::SUM_W-1:0]   sum_ax_ff;
   logic signed [nga_pkg::SUM_W-1:0]   sum_ay_ff;
   logic                               rsp_valid_ff;

   logic [nga_pkg::MAG_W-1:0]          dx_mag_ff;
   logic [nga_pkg::MAG_W-1:0]          dy_mag_ff;
   logic                               dx_neg_ff;
   logic                               dy_neg_ff;
   logic [nga_pkg::MASS_W-1:0]         mass_ff;
   logic                               last_ff;
   logic signed [nga_pkg::VEL_W-1:0]   vx_ff;
   logic signed [nga_pkg::VEL_W-1:0]   vy_ff;
   logic [nga_pkg::WIDE_W-1:0]         wide_ff;
   logic [nga_pkg::MAG_W-1:0]          r_ff;
   logic [nga_pkg::R3_W-1:0]           r3_ff;
   logic [nga_pkg::GM_W-1:0]           gm_ff;
   logic signed [nga_pkg::VEL_W-1:0]   rsp_vel_x_ff;
   logic signed [nga_pkg::VEL_W-1:0]   rsp_vel_y_ff;
   logic signed [nga_pkg::SUM_W-1:0]   rsp_acc_x_ff;
   logic signed [nga_pkg::SUM_W-1:0]   rsp_acc_y_ff;

   logic                               req_fire;
   logic                               eng_phase;
   logic                               fin_load;
   logic signed [nga_pkg::MAG_W-1:0]   dx_in;
   logic signed [nga_pkg::MAG_W-1:0]   dy_in;
   logic [nga_pkg::QUO_W-1:0]          term_mag;
   logic                               in_range;
   nga_pkg::eng_cmd_type               eng_cmd;
   nga_pkg::eng_sts_type               eng_sts;
   logic [nga_pkg::WIDE_W-1:0]         eng_a;
   logic [nga_pkg::R3_W-1:0]           eng_b;
   logic [nga_pkg::WIDE_W-1:0]         eng_res_wide;
   logic [nga_pkg::QUO_W-1:0]          eng_res_narrow;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign fin_load  = (state_ff == ST_FIN) && last_ff && (!rsp_valid_ff || rsp_ready);

   // Separations, clamped quotient and distance range check
   always_comb begin
      dx_in    = {req_query_x[nga_pkg::POS_W-1], req_query_x}
               - {req_other_x[nga_pkg::POS_W-1], req_other_x};
      dy_in    = {req_query_y[nga_pkg::POS_W-1], req_query_y}
               - {req_other_y[nga_pkg::POS_W-1], req_other_y};
      term_mag = eng_res_narrow[nga_pkg::QUO_W-1]
               ? {1'b1, {(nga_pkg::QUO_W-1){1'b0}}}
               : {1'b0, eng_res_narrow[nga_pkg::QUO_W-2:0]};
      in_range = (eng_res_narrow[nga_pkg::MAG_W-1:0] >= {2'b00, min_dist_ff})
              && (eng_res_narrow[nga_pkg::MAG_W-1:0] != '0);
   end

   // Select the engine operation and its operands for the current step
   always_comb begin
      eng_phase = 1'b1;
      eng_cmd.op = nga_pkg::OP_MUL;
      eng_a = '0;
      eng_b = '0;
      unique case (state_ff) inside
         ST_SQX: begin
            eng_a = {87'd0, dx_mag_ff};
            eng_b = {82'd0, dx_mag_ff};
         end
         ST_SQY: begin
            eng_a = {87'd0, dy_mag_ff};
            eng_b = {82'd0, dy_mag_ff};
         end
         ST_ROOT: begin
            eng_cmd.op = nga_pkg::OP_SQRT;
            eng_a = wide_ff;
         end
         ST_R2: begin
            eng_a = {87'd0, r_ff};
            eng_b = {82'd0, r_ff};
         end
         ST_R3: begin
            eng_a = wide_ff;
            eng_b = {82'd0, r_ff};
         end
         ST_GM: begin
            eng_a = {88'd0, mass_ff};
            eng_b = {91'd0, grav_ff};
         end
         ST_NX: begin
            eng_a = {48'd0, gm_ff, 8'd0};
            eng_b = {82'd0, dx_mag_ff};
         end
         ST_NY: begin
            eng_a = {48'd0, gm_ff, 8'd0};
            eng_b = {82'd0, dy_mag_ff};
         end
         ST_DX, ST_DY: begin
            eng_cmd.op = nga_pkg::OP_DIV;
            eng_a = wide_ff;
            eng_b = r3_ff;
         end
         default: begin
            eng_phase = 1'b0;
         end
      endcase
      eng_cmd.start = eng_phase && !issued_ff;
   end

   nga_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd        (eng_cmd),
      .opnd_a     (eng_a),
      .opnd_b     (eng_b),
      .sts        (eng_sts),
      .res_wide   (eng_res_wide),
      .res_narrow (eng_res_narrow)
   );

   // Sequencer, engine issue flag, CSRs, sums and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         grav_ff      <= nga_pkg::GRAV_RESET;
         min_dist_ff  <= nga_pkg::MIN_RESET;
         sum_ax_ff    <= '0;
         sum_ay_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               nga_pkg::CSR_GRAV: grav_ff     <= csr_wdata[nga_pkg::GRAV_W-1:0];
               nga_pkg::CSR_MIN:  min_dist_ff <= csr_wdata;
               default:           min_dist_ff <= min_dist_ff;
            endcase
         end

         if (eng_cmd.start) begin
            issued_ff <= 1'b1;
         end else if (eng_sts.done) begin
            issued_ff <= 1'b0;
         end

         if (fin_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= (req_skip || (req_other_mass == '0)) ? ST_FIN : ST_SQX;
               end
            end
            ST_SQX:  if (eng_sts.done) state_ff <= ST_SQY;
            ST_SQY:  if (eng_sts.done) state_ff <= ST_ROOT;
            ST_ROOT: if (eng_sts.done) state_ff <= in_range ? ST_R2 : ST_FIN;
            ST_R2:   if (eng_sts.done) state_ff <= ST_R3;
            ST_R3:   if (eng_sts.done) state_ff <= ST_GM;
            ST_GM:   if (eng_sts.done) state_ff <= ST_NX;
            ST_NX:   if (eng_sts.done) state_ff <= ST_DX;
            ST_DX: begin
               if (eng_sts.done) begin
                  sum_ax_ff <= nga_pkg::sat_acc(sum_ax_ff, dx_neg_ff, term_mag);
                  state_ff  <= ST_NY;
               end
            end
            ST_NY:   if (eng_sts.done) state_ff <= ST_DY;
            ST_DY: begin
               if (eng_sts.done) begin
                  sum_ay_ff <= nga_pkg::sat_acc(sum_ay_ff, dy_neg_ff, term_mag);
                  state_ff  <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (!last_ff) begin
                  state_ff <= ST_IDLE;
               end else if (fin_load) begin
                  sum_ax_ff <= '0;
                  sum_ay_ff <= '0;
                  state_ff  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Item, intermediate and result payload: capture on accept, on engine done and on result load
   always_ff @(posedge clock) begin
      if (req_fire) begin
         dx_mag_ff <= dx_in[nga_pkg::MAG_W-1] ? (-dx_in) : dx_in;
         dy_mag_ff <= dy_in[nga_pkg::MAG_W-1] ? (-dy_in) : dy_in;
         dx_neg_ff <= dx_in[nga_pkg::MAG_W-1];
         dy_neg_ff <= dy_in[nga_pkg::MAG_W-1];
         mass_ff   <= req_other_mass;
         last_ff   <= req_last;
         vx_ff     <= req_query_vx;
         vy_ff     <= req_query_vy;
      end
      if (eng_sts.done) begin
         case (state_ff) inside
            ST_SQX, ST_R2, ST_NX, ST_NY: wide_ff <= eng_res_wide;
            ST_SQY:  wide_ff <= wide_ff + eng_res_wide;
            ST_ROOT: r_ff    <= eng_res_narrow[nga_pkg::MAG_W-1:0];
            ST_R3:   r3_ff   <= eng_res_wide[nga_pkg::R3_W-1:0];
            ST_GM:   gm_ff   <= eng_res_wide[nga_pkg::GM_W-1:0];
            default: gm_ff   <= gm_ff;
         endcase
      end
      if (fin_load) begin
         rsp_vel_x_ff <= vx_ff;
         rsp_vel_y_ff <= vy_ff;
         rsp_acc_x_ff <= sum_ax_ff;
         rsp_acc_y_ff <= sum_ay_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_vel_x = rsp_vel_x_ff;
   assign rsp_vel_y = rsp_vel_y_ff;
   assign rsp_acc_x = rsp_acc_x_ff;
   assign rsp_acc_y = rsp_acc_y_ff;

   `NGA_ASSERT(a_eng_no_restart, eng_cmd.start |-> !eng_sts.busy, "engine restarted while busy")
   `NGA_ASSERT(a_fin_clears, fin_load |=> (sum_ax_ff == '0) && (sum_ay_ff == '0) && rsp_valid_ff, "sums not cleared on result")
   `NGA_ASSERT(a_idle_holds, (state_ff == ST_IDLE) && !req_valid |=> (state_ff == ST_IDLE), "left idle without a beat")
   `NGA_ASSERT(a_done_issued, eng_sts.done |-> issued_ff, "engine done without a command")

endmodule

[bench/testbench.sv]
// Self-checking testbench for the gravity accumulator: directed table, then random body sets.
`timescale 1ns / 100ps

module testbench;

   localparam logic signed [nga_pkg::SUM_W-1:0] SUM_HI = {1'b0, {(nga_pkg::SUM_W-1){1'b1}}};
   localparam logic signed [nga_pkg::SUM_W-1:0] SUM_LO = {1'b1, {(nga_pkg::SUM_W-1){1'b0}}};
   localparam logic [127:0] TERM_CAP = 128'd1 << 48;
   localparam int DRAIN_CYCLES = 600;

   typedef enum logic {ROW_BODY, ROW_CSR} row_kind_type;

   typedef struct {
      logic signed [nga_pkg::POS_W-1:0]  qx, qy, ox, oy;
      logic signed [nga_pkg::VEL_W-1:0]  vx, vy;
      logic        [nga_pkg::MASS_W-1:0] mass;
      logic                              skip, last;
   } body_type;

   typedef struct {
      logic signed [nga_pkg::VEL_W-1:0] vel_x, vel_y;
      logic signed [nga_pkg::SUM_W-1:0] acc_x, acc_y;
   } state_deriv_type;

   typedef struct {
      row_kind_type              kind;
      body_type                  body;
      logic                      known;
      state_deriv_type           want;
      logic                      csr_sel;
      logic [nga_pkg::MIN_W-1:0] csr_val;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [nga_pkg::POS_W-1:0]  req_query_x = '0, req_query_y = '0;
   logic signed [nga_pkg::VEL_W-1:0]  req_query_vx = '0, req_query_vy = '0;
   logic signed [nga_pkg::POS_W-1:0]  req_other_x = '0, req_other_y = '0;
   logic        [nga_pkg::MASS_W-1:0] req_other_mass = '0;
   logic req_skip = 1'b0, req_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [nga_pkg::VEL_W-1:0] rsp_vel_x, rsp_vel_y;
   logic signed [nga_pkg::SUM_W-1:0] rsp_acc_x, rsp_acc_y;
   logic                      csr_write_en = 1'b0;
   logic                      csr_index = nga_pkg::CSR_GRAV;
   logic [nga_pkg::MIN_W-1:0] csr_wdata = '0;

   // model copy of the registers and running sums
   logic [nga_pkg::GRAV_W-1:0]       g_scaled;
   logic [nga_pkg::MIN_W-1:0]        r_floor;
   logic signed [nga_pkg::SUM_W-1:0] pull_x, pull_y;

   state_deriv_type pending_derivs[$];
   row_type         rows[$];
   int              mismatches = 0;
   int              burst_left = 0;

   nbody_gravity_accumulator dut (.*);

   always #2 clock = ~clock;

   // Clamped term magnitude for one axis.
   function automatic logic [127:0] axis_term(input logic [127:0] gm, input logic [127:0] mag,
                                              input logic [127:0] r3);
      logic [127:0] q;
      q = (gm * (mag << 8)) / r3;
      return (q >= TERM_CAP) ? TERM_CAP : q;
   endfunction

   // Pull the term toward the other body and clamp to 48 bits.
   function automatic logic signed [nga_pkg::SUM_W-1:0] pull_sat(
      input logic signed [nga_pkg::SUM_W-1:0] s,
      input logic signed [nga_pkg::POS_W:0]   d,
      input logic [127:0]                     mag
   );
      logic signed [nga_pkg::SUM_W+1:0] t;
      logic signed [nga_pkg::SUM_W+1:0] m;
      logic signed [nga_pkg::SUM_W+1:0] s_ext;
      m = $signed({1'b0, mag[nga_pkg::SUM_W:0]});
      s_ext = $signed({{2{s[nga_pkg::SUM_W-1]}}, s});
      t = (d >= 0) ? (s_ext - m) : (s_ext + m);
      if (t > $signed({{2{1'b0}}, SUM_HI})) return SUM_HI;
      if (t < $signed({{2{1'b1}}, SUM_LO})) return SUM_LO;
      return t[nga_pkg::SUM_W-1:0];
   endfunction

   // Fold one body into the sums; emit the derivative on the last body.
   function automatic bit fold_body(input body_type b, output state_deriv_type d);
      logic signed [nga_pkg::POS_W:0] dx, dy;
      logic [127:0] mx, my, n, root, t, r3, gm;
      dx = {b.qx[nga_pkg::POS_W-1], b.qx} - {b.ox[nga_pkg::POS_W-1], b.ox};
      dy = {b.qy[nga_pkg::POS_W-1], b.qy} - {b.oy[nga_pkg::POS_W-1], b.oy};
      mx = (dx < 0) ? 128'(-dx) : 128'(dx);
      my = (dy < 0) ? 128'(-dy) : 128'(dy);
      if (!b.skip && b.mass != 0) begin
         n = mx * mx + my * my;
         root = '0;
         for (int i = 41; i >= 0; i--) begin
            t = root | (128'd1 << i);
            if (t * t <= n) root = t;
         end
         if (root >= 128'(r_floor) && root != 0) begin
            r3 = root * root * root;
            gm = 128'(g_scaled) * 128'(b.mass);
            pull_x = pull_sat(pull_x, dx, axis_term(gm, mx, r3));
            pull_y = pull_sat(pull_y, dy, axis_term(gm, my, r3));
         end
      end
      d.vel_x = b.vx;
      d.vel_y = b.vy;
      d.acc_x = pull_x;
      d.acc_y = pull_y;
      if (b.last) begin
         pull_x = '0;
         pull_y = '0;
      end
      return b.last;
   endfunction

   // Offer one body, honoring burst and gap pacing, and hold until accepted.
   task automatic send_body(input body_type b, input logic known, input state_deriv_type want);
      int gap;
      state_deriv_type d;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_valid      <= 1'b1;
      req_query_x    <= b.qx;
      req_query_y    <= b.qy;
      req_query_vx   <= b.vx;
      req_query_vy   <= b.vy;
      req_other_x    <= b.ox;
      req_other_y    <= b.oy;
      req_other_mass <= b.mass;
      req_skip       <= b.skip;
      req_last       <= b.last;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      burst_left--;
      if (fold_body(b, d)) pending_derivs.insert(pending_derivs.size(), known ? want : d);
   endtask

   // Drain, let the engine settle, then write one register.
   task automatic write_csr(input logic sel, input logic [nga_pkg::MIN_W-1:0] val);
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_derivs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= sel;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (sel == nga_pkg::CSR_GRAV) g_scaled = val[nga_pkg::GRAV_W-1:0];
      else r_floor = val;
   endtask

   task automatic add_body(input body_type b, input logic known, input state_deriv_type want);
      row_type r;
      r.kind = ROW_BODY;
      r.body = b;
      r.known = known;
      r.want = want;
      r.csr_sel = nga_pkg::CSR_GRAV;
      r.csr_val = '0;
      rows.insert(rows.size(), r);
   endtask

   task automatic add_csr(input logic sel, input logic [nga_pkg::MIN_W-1:0] val);
      row_type r;
      r.kind = ROW_CSR;
      r.known = 1'b0;
      r.csr_sel = sel;
      r.csr_val = val;
      rows.insert(rows.size(), r);
   endtask

   function automatic body_type mk(input logic signed [nga_pkg::POS_W-1:0] qx, qy, ox, oy,
                                   input logic signed [nga_pkg::VEL_W-1:0] vx, vy,
                                   input logic [nga_pkg::MASS_W-1:0] mass,
                                   input logic skip, last);
      body_type b;
      b.qx = qx; b.qy = qy; b.ox = ox; b.oy = oy;
      b.vx = vx; b.vy = vy; b.mass = mass; b.skip = skip; b.last = last;
      return b;
   endfunction

   function automatic state_deriv_type deriv(input logic signed [nga_pkg::VEL_W-1:0] vx, vy,
                                             input logic signed [nga_pkg::SUM_W-1:0] ax, ay);
      state_deriv_type d;
      d.vel_x = vx; d.vel_y = vy; d.acc_x = ax; d.acc_y = ay;
      return d;
   endfunction

   // Random body: mostly a well-formed offset of random scale, some pure noise.
   function automatic body_type random_body(input logic last);
      body_type b;
      logic [63:0] rx, ry, w;
      int k;
      w = {$urandom, $urandom};
      b.qx = w[nga_pkg::POS_W-1:0];
      w = {$urandom, $urandom};
      b.qy = w[nga_pkg::POS_W-1:0];
      b.vx = $urandom;
      b.vy = $urandom;
      if ($urandom_range(0, 7) == 0) begin
         w = {$urandom, $urandom};
         b.ox = w[nga_pkg::POS_W-1:0];
         w = {$urandom, $urandom};
         b.oy = w[nga_pkg::POS_W-1:0];
      end else begin
         k = $urandom_range(0, 39);
         rx = {$urandom, $urandom} & ((64'd1 << k) - 1);
         ry = {$urandom, $urandom} & ((64'd1 << k) - 1);
         if ($urandom_range(0, 1)) rx = -rx;
         if ($urandom_range(0, 1)) ry = -ry;
         b.ox = b.qx - rx[nga_pkg::POS_W-1:0];
         b.oy = b.qy - ry[nga_pkg::POS_W-1:0];
      end
      case ($urandom_range(0, 15)) inside
         0: b.mass = '0;
         1, 2, 3: begin
            w = {$urandom, $urandom};
            b.mass = w[nga_pkg::MASS_W-1:0];
         end
         default: begin
            w = {$urandom, $urandom} & ((64'd1 << $urandom_range(1, 39)) - 1);
            b.mass = w[nga_pkg::MASS_W-1:0];
         end
      endcase
      if (b.mass == 0 && $urandom_range(0, 1)) b.mass = 40'd1;
      b.skip = ($urandom_range(0, 15) == 0);
      b.last = last;
      return b;
   endfunction

   // Receiver: stall pattern in modes, and check each result beat.
   int stall_mode = 0;
   int mode_left = 0;
   always @(posedge clock) begin
      state_deriv_type w;
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         mode_left <= $urandom_range(8, 200);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_derivs.size() == 0) begin
            $display("%0t: result beat with nothing expected: vel %0d %0d acc %0d %0d",
                     $realtime, rsp_vel_x, rsp_vel_y, rsp_acc_x, rsp_acc_y);
            mismatches++;
         end else begin
            w = pending_derivs.pop_front();
            if (rsp_vel_x !== w.vel_x) begin
               $display("%0t: vel_x expected %0d actual %0d", $realtime, w.vel_x, rsp_vel_x);
               mismatches++;
            end
            if (rsp_vel_y !== w.vel_y) begin
               $display("%0t: vel_y expected %0d actual %0d", $realtime, w.vel_y, rsp_vel_y);
               mismatches++;
            end
            if (rsp_acc_x !== w.acc_x) begin
               $display("%0t: acc_x expected %0d actual %0d", $realtime, w.acc_x, rsp_acc_x);
               mismatches++;
            end
            if (rsp_acc_y !== w.acc_y) begin
               $display("%0t: acc_y expected %0d actual %0d", $realtime, w.acc_y, rsp_acc_y);
               mismatches++;
            end
         end
      end
   end

   // Stimulus: reset, directed table, random phases over several settings.
   initial begin
      state_deriv_type none;
      logic [nga_pkg::GRAV_W-1:0] gset[8];
      logic [nga_pkg::MIN_W-1:0]  mset[8];
      none = deriv(0, 0, 0, 0);
      g_scaled = nga_pkg::GRAV_RESET;
      r_floor = nga_pkg::MIN_RESET;
      pull_x = '0;
      pull_y = '0;

      // defaults: skipped, massless and too-close bodies on last, then far and extreme-coordinate bodies
      add_body(mk(0, 0, 100, 0, 32'sh7fffffff, 32'sh80000000, 40'd7, 1, 1), 1,
               deriv(32'sh7fffffff, 32'sh80000000, 0, 0));
      add_body(mk(0, 0, 100000000, 0, -5, 9, 40'd0, 0, 1), 1, deriv(-5, 9, 0, 0));
      add_body(mk(1000, 0, 0, 0, 3, 4, 40'd1000, 0, 1), 1, deriv(3, 4, 0, 0));
      add_body(mk(100000000, 0, 0, 0, 1, 2, 40'd1000, 0, 0), 0, none);
      add_body(mk(0, -70000000, 0, 0, 1, 2, 40'd5000, 0, 1), 0, none);
      add_body(mk(40'sh7fffffffff, 40'sh8000000000, 40'sh8000000000, 40'sh7fffffffff,
                  0, 0, 40'hffffffffff, 0, 1), 0, none);
      add_body(mk(40'sh8000000000, 40'sh7fffffffff, 40'sh7fffffffff, 40'sh8000000000,
                  -1, -1, 40'hffffffffff, 0, 1), 0, none);
      add_body(mk(5000000, 0, 0, 0, 0, 0, 40'hffffffffff, 0, 1), 0, none);
      // strongest constant, no distance floor: zero separation and clamped terms; then a zero constant
      add_csr(nga_pkg::CSR_GRAV, 39'(32'hffffffff));
      add_csr(nga_pkg::CSR_MIN, '0);
      add_body(mk(123, 456, 123, 456, 7, 8, 40'hffffffffff, 0, 1), 1, deriv(7, 8, 0, 0));
      add_body(mk(1, 0, 0, 0, 1, 1, 40'hffffffffff, 0, 1), 1, deriv(1, 1, SUM_LO, 0));
      add_body(mk(-1, 1, 0, 0, 2, 2, 40'hffffffffff, 0, 1), 1, deriv(2, 2, SUM_HI, SUM_LO));
      add_body(mk(1, 0, 0, 0, 0, 0, 40'hffffffffff, 0, 0), 0, none);
      add_body(mk(1, 0, 0, 0, 0, 0, 40'hffffffffff, 0, 0), 0, none);
      add_body(mk(-3, 5, 0, 0, 0, 0, 40'd1, 0, 1), 0, none);
      add_csr(nga_pkg::CSR_GRAV, '0);
      add_body(mk(1000, 1000, 0, 0, 5, 6, 40'hffffffffff, 0, 1), 1, deriv(5, 6, 0, 0));
      // widest distance floor
      add_csr(nga_pkg::CSR_GRAV, 39'(nga_pkg::GRAV_RESET));
      add_csr(nga_pkg::CSR_MIN, {nga_pkg::MIN_W{1'b1}});
      add_body(mk(40'sh7fffffffff, 0, 40'sh8000000000, 0, 0, 0, 40'hffffffffff, 0, 1), 0,
               none);
      add_body(mk(40'sh3fffffffff, 0, 0, 0, 0, 0, 40'hffffffffff, 0, 1), 1,
               deriv(0, 0, 0, 0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table
      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) write_csr(rows[i].csr_sel, rows[i].csr_val);
         else send_body(rows[i].body, rows[i].known, rows[i].want);
      end

      // random phases, extremes among the settings
      gset = '{nga_pkg::GRAV_RESET, 32'hffffffff, 32'd0, $urandom, nga_pkg::GRAV_RESET,
               32'd1, $urandom, 32'hffffffff};
      mset = '{39'd0, 39'd0, 39'd1000, {nga_pkg::MIN_W{1'b1}},
               39'($urandom_range(0, 1 << 24)), 39'd0,
               39'($urandom_range(0, 1 << 30)), 39'($urandom_range(0, 1 << 12))};
      for (int p = 0; p < 8; p++) begin
         write_csr(nga_pkg::CSR_GRAV, 39'(gset[p]));
         write_csr(nga_pkg::CSR_MIN, mset[p]);
         for (int j = 0; j < 235; j++)
            send_body(random_body(j == 234 || $urandom_range(0, 7) == 0), 0, none);
      end

      // drain and let the engine settle
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_derivs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_derivs.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Bound the run.
   initial begin
      #25000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/nga_pkg.sv
hw/rtl/nga_engine.sv
hw/rtl/nbody_gravity_accumulator.sv
bench/testbench.sv
